>>> src/hdpd_pkg.sv
// package for the hysteresis debounce presence detector
// field widths, register indexes, reset values and detection codes
// no dependencies
package hdpd_pkg;

   localparam int CHAN_W  = 4;
   localparam int DIST_W  = 12;
   localparam int COUNT_W = 4;
   localparam int DET_W   = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   localparam int NUM_CHANNELS_DEFAULT = 16;
   localparam int NUM_CHANNELS_MAX     = 256;

   localparam logic              ENABLE_RST          = 1'b1;
   localparam logic [DIST_W-1:0] ENTER_THRESHOLD_RST = 12'd20;
   localparam logic [DIST_W-1:0] EXIT_THRESHOLD_RST  = 12'd30;
   localparam logic [COUNT_W-1:0] DEBOUNCE_COUNT_RST = 4'd3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENABLE          = 2'd0,
      CSR_ENTER_THRESHOLD = 2'd1,
      CSR_EXIT_THRESHOLD  = 2'd2,
      CSR_DEBOUNCE_COUNT  = 2'd3
   } csr_index_type;

   typedef enum logic [DET_W-1:0] {
      DET_CLEAR    = 2'd0,
      DET_DETECTED = 2'd1,
      DET_UNKNOWN  = 2'd2
   } detection_type;

endpackage

>>> src/hdpd_intf.sv
// request and response channel interfaces, valid/ready handshake
// depends on hdpd_pkg for the field widths
interface hdpd_req_if
   import hdpd_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] channel;
   logic [DIST_W-1:0] distance;
   logic              invalid;

   modport source (output valid, output channel, output distance, output invalid,
                   input ready);
   modport sink   (input valid, input channel, input distance, input invalid,
                   output ready);
endinterface

interface hdpd_rsp_if
   import hdpd_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [DET_W-1:0]  detection;
   logic [CHAN_W-1:0] channel_out;

   modport source (output valid, output detection, output channel_out, input ready);
   modport sink   (input valid, input detection, input channel_out, output ready);
endinterface

>>> src/hysteresis_debounce_presence_detector.sv
// a request is captured in the input stage registers, then its response is registered in the output stage
// throughput: one request per cycle, held back only by response backpressure
// the single evaluate stage reads and updates the channel table
// reset: channel table cleared, registers back to their defaults
// depends on hdpd_pkg and the channel interfaces in hdpd_intf
module hysteresis_debounce_presence_detector
   import hdpd_pkg::*;
#(
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   hdpd_req_if.sink              req_chan,
   hdpd_rsp_if.source            rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CHAN_SPAN = 1 << CHAN_W;
   localparam int DEPTH = (NUM_CHANNELS < CHAN_SPAN) ? NUM_CHANNELS : CHAN_SPAN;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CMP_W = $clog2(NUM_CHANNELS_MAX + 1);

   // configuration registers
   logic               enable_ff;
   logic [DIST_W-1:0]  enter_thr_ff;
   logic [DIST_W-1:0]  exit_thr_ff;
   logic [COUNT_W-1:0] debounce_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= ENABLE_RST;
         enter_thr_ff <= ENTER_THRESHOLD_RST;
         exit_thr_ff  <= EXIT_THRESHOLD_RST;
         debounce_ff  <= DEBOUNCE_COUNT_RST;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_ENABLE:          enable_ff    <= csr_wdata[0];
            CSR_ENTER_THRESHOLD: enter_thr_ff <= csr_wdata[DIST_W-1:0];
            CSR_EXIT_THRESHOLD:  exit_thr_ff  <= csr_wdata[DIST_W-1:0];
            CSR_DEBOUNCE_COUNT:  debounce_ff  <= csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // input stage
   logic              s1_valid_ff, s1_valid_in;
   logic [CHAN_W-1:0] s1_channel_ff;
   logic [DIST_W-1:0] s1_distance_ff;
   logic              s1_invalid_ff;

   // output stage
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DET_W-1:0]  rsp_det_ff, rsp_det_in;
   logic [CHAN_W-1:0] rsp_chan_ff;

   // channel table
   logic [DEPTH-1:0]   det_ff, det_in;
   logic [DEPTH-1:0]   primed_ff, primed_in;
   logic [DEPTH-1:0]   cand_ff, cand_in;
   logic [COUNT_W-1:0] count_ff [DEPTH];
   logic [COUNT_W-1:0] count_in [DEPTH];

   logic               in_range, emit, out_free, s1_move;
   logic [IDX_W-1:0]   idx;
   logic               cur_det, cur_primed, cur_cand;
   logic [COUNT_W-1:0] cur_count;
   logic [DIST_W-1:0]  thr;
   logic               cand, agree, new_det;
   logic [COUNT_W-1:0] new_count;

   assign in_range = CMP_W'(s1_channel_ff) < CMP_W'(NUM_CHANNELS);
   assign emit     = s1_valid_ff && enable_ff && in_range;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign s1_move  = s1_valid_ff && (!emit || out_free);
   assign req_chan.ready = !s1_valid_ff || s1_move;
   assign idx = in_range ? s1_channel_ff[IDX_W-1:0] : '0;

   always_comb begin
      cur_det    = det_ff[idx];
      cur_primed = primed_ff[idx];
      cur_cand   = cand_ff[idx];
      cur_count  = count_ff[idx];
      thr        = cur_det ? exit_thr_ff : enter_thr_ff;
      cand       = s1_distance_ff <= thr;
      agree      = cur_primed && (cand == cur_cand);
      if (agree) begin
         new_count = (cur_count < debounce_ff) ? cur_count + 1'b1 : cur_count;
      end else begin
         new_count = COUNT_W'(1);
      end
      new_det = (new_count >= debounce_ff) ? cand : cur_det;

      det_in    = det_ff;
      primed_in = primed_ff;
      cand_in   = cand_ff;
      count_in  = count_ff;
      if (emit && s1_move) begin
         if (s1_invalid_ff) begin
            det_in[idx]    = 1'b0;
            primed_in[idx] = 1'b0;
            cand_in[idx]   = 1'b0;
            count_in[idx]  = '0;
         end else begin
            det_in[idx]    = new_det;
            primed_in[idx] = 1'b1;
            cand_in[idx]   = cand;
            count_in[idx]  = new_count;
         end
      end

      if (s1_invalid_ff) begin
         rsp_det_in = DET_UNKNOWN;
      end else if (new_det) begin
         rsp_det_in = DET_DETECTED;
      end else begin
         rsp_det_in = DET_CLEAR;
      end

      if (emit && s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      if (req_chan.valid && req_chan.ready) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         det_ff       <= '0;
         primed_ff    <= '0;
         cand_ff      <= '0;
         for (int i = 0; i < DEPTH; i++) begin
            count_ff[i] <= '0;
         end
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         det_ff       <= det_in;
         primed_ff    <= primed_in;
         cand_ff      <= cand_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         s1_channel_ff  <= req_chan.channel;
         s1_distance_ff <= req_chan.distance;
         s1_invalid_ff  <= req_chan.invalid;
      end
      if (emit && s1_move) begin
         rsp_det_ff  <= rsp_det_in;
         rsp_chan_ff <= s1_channel_ff;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.detection   = rsp_det_ff;
   assign rsp_chan.channel_out = rsp_chan_ff;

endmodule
